[design/hlt_pkg.sv]
// Shared types, constants and event codes for the heartbeat liveness table.
// No dependencies; every other design file imports this package.
package hlt_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int MAX_RESULTS     = 20;
	localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef logic [21:0] sender_t;
	typedef logic [31:0] time_t;
	typedef logic [15:0] tmo_t;
	typedef logic [2:0]  status_t;
	typedef logic [4:0]  slot_t;

	localparam tmo_t    TIMEOUT_RST    = 16'd35;
	localparam status_t OFFLINE_STATUS = 3'd6;

	typedef enum logic [2:0] {
		EV_UPDATED     = 3'd0,
		EV_ADDED       = 3'd1,
		EV_OFFLINE     = 3'd2,
		EV_TIMEOUT     = 3'd3,
		EV_FULL        = 3'd4,
		EV_ALL_OFFLINE = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MSG,
		ST_OFF_RM,
		ST_SWEEP,
		ST_ALL_OFF,
		ST_FIN
	} state_t;

	// Per-slot control: shift takes the neighbour's entry, load writes a new
	// entry, touch refreshes the last-heard time only.
	typedef struct packed {
		logic shift;
		logic load;
		logic touch;
	} cell_ctrl_t;

	typedef struct packed {
		event_t  ev;
		slot_t   slot;
		sender_t sender;
		status_t status;
	} result_t;

endpackage

[design/hlt_cell.sv]
// One slot of the liveness table: sender, last-heard time, match and expiry.
// Depends on hlt_pkg.
module hlt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  hlt_pkg::cell_ctrl_t ctrl,
	input  hlt_pkg::sender_t    key,
	input  hlt_pkg::time_t      now,
	input  hlt_pkg::tmo_t       timeout,
	input  hlt_pkg::sender_t    nbr_sender,
	input  hlt_pkg::time_t      nbr_heard,
	output hlt_pkg::sender_t    sender,
	output hlt_pkg::time_t      heard,
	output logic                match,
	output logic                expired
);
	import hlt_pkg::*;

	sender_t sender_q;
	time_t   heard_q;
	time_t   diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sender_q <= '0;
			heard_q  <= '0;
		end else if (ctrl.shift) begin
			sender_q <= nbr_sender;
			heard_q  <= nbr_heard;
		end else if (ctrl.load) begin
			sender_q <= key;
			heard_q  <= now;
		end else if (ctrl.touch) begin
			heard_q <= now;
		end
	end

	// A clock running backwards counts as no silence at all.
	assign diff    = now - heard_q;
	assign match   = (sender_q != '0) && (sender_q == key);
	assign expired = (sender_q != '0) && (now > heard_q) && (diff > time_t'(timeout));
	assign sender  = sender_q;
	assign heard   = heard_q;

endmodule

[design/hlt_emit.sv]
// Result staging: holds one result back so that the final one carries last.
// Depends on hlt_pkg.
module hlt_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             emit_v,
	input  hlt_pkg::result_t emit_r,
	input  logic             flush,
	output logic             strobe,
	output hlt_pkg::result_t res,
	output logic             res_last
);
	import hlt_pkg::*;

	logic                 pend_v_q;
	result_t              pend_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 strobe_q;
	logic                 last_q;
	result_t              out_q;
	logic                 take;

	// Results beyond the per-transaction limit are dropped.
	assign take = emit_v && !flush && (cnt_q < RES_CNT_W'(MAX_RESULTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (flush) begin
				strobe_q <= pend_v_q;
				last_q   <= 1'b1;
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
			end else if (take) begin
				strobe_q <= pend_v_q;
				last_q   <= 1'b0;
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_q <= emit_r;
		end
		if (flush || take) begin
			out_q <= pend_q;
		end
	end

	assign strobe   = strobe_q;
	assign res      = out_q;
	assign res_last = last_q;

endmodule

[design/heartbeat_liveness_table_top.sv]
// Heartbeat liveness table, top level: a row of slot cells and the sequencer.
// Sequence: busy is high for the message part (non-zero sender), an offline removal, a sweep
// step for each live slot examined, removed or not, and a closing step unless the list
// empties, the all-offline result and a finishing step, in that order. The final result is on
// the ports in the first cycle with busy low.
// Throughput: one transaction at a time; the next one may be accepted at the edge that takes
// the final result of the previous one. The receiver cannot stall.
// Reset (arst_n, asynchronous, active low) empties every slot and sets the timeout to 35 s.
// Depends on hlt_pkg, hlt_cell and hlt_emit.
module heartbeat_liveness_table_top #(
	parameter int MAX_ENTRIES = hlt_pkg::MAX_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  hlt_pkg::sender_t sender_id,
	input  hlt_pkg::status_t hb_status,
	input  logic             offline_flag,
	input  hlt_pkg::time_t   now_seconds,
	input  logic             timeout_we,
	input  hlt_pkg::tmo_t    timeout_wdata,
	output logic             result_strobe,
	output logic [2:0]       event_res,
	output hlt_pkg::slot_t   slot,
	output hlt_pkg::sender_t event_sender,
	output hlt_pkg::status_t event_status,
	output logic             last
);
	import hlt_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	// Sequencer state and the latched transaction.
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] p_q;
	logic [IDX_W-1:0] k_q;
	logic             terminated_q;
	tmo_t             timeout_q;
	sender_t          key_q;
	status_t          status_q;
	logic             offline_q;
	time_t            now_q;
	sender_t          rm_snd_q;

	// The row of cells.
	cell_ctrl_t       cell_ctrl [MAX_ENTRIES];
	sender_t          cell_snd  [MAX_ENTRIES];
	time_t            cell_hrd  [MAX_ENTRIES];
	sender_t          nbr_snd   [MAX_ENTRIES];
	time_t            nbr_hrd   [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] expired;

	logic             accept_go;
	logic             found;
	logic [IDX_W-1:0] k;
	logic [IDX_W-1:0] p_idx;
	logic             p_live;
	logic             exp_p;
	logic             touch_en;
	logic             add_en;
	logic             rm_en;
	logic [IDX_W-1:0] rm_idx;
	logic             p_inc;
	logic             emit_v;
	result_t          emit_r;
	logic             flush;
	result_t          res;

	// An item offered after the list has gone all-offline is not accepted and
	// gives no result.
	assign busy      = (state_q != ST_IDLE);
	assign accept_go = start && !busy && !terminated_q;

	// Each cell compares itself against the key; senders are unique, so at
	// most one cell matches and its index is the OR of the matching indices.
	assign found = |match;
	always_comb begin
		k = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match[i]) begin
				k = k | IDX_W'(i);
			end
		end
	end

	// The sweep pointer walks the live part of the list; slots at or beyond
	// the count are empty because the list is kept compact.
	assign p_idx  = p_q[IDX_W-1:0];
	assign p_live = (p_q < count_q);
	assign exp_p  = p_live && expired[p_idx];

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign nbr_snd[i] = '0;
			assign nbr_hrd[i] = '0;
		end else begin : g_body
			assign nbr_snd[i] = cell_snd[i+1];
			assign nbr_hrd[i] = cell_hrd[i+1];
		end

		// A removal makes every cell from the removed slot onwards take its
		// neighbour's entry, the last cell taking an empty one.
		assign cell_ctrl[i] = '{
			shift: rm_en && (IDX_W'(i) >= rm_idx),
			load:  add_en && (CNT_W'(i) == count_q),
			touch: touch_en && match[i]
		};

		hlt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl[i]),
			.key        (key_q),
			.now        (now_q),
			.timeout    (timeout_q),
			.nbr_sender (nbr_snd[i]),
			.nbr_heard  (nbr_hrd[i]),
			.sender     (cell_snd[i]),
			.heard      (cell_hrd[i]),
			.match      (match[i]),
			.expired    (expired[i])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_go) begin
					state_d = (sender_id != '0) ? ST_MSG : ST_SWEEP;
				end
			end
			ST_MSG: begin
				state_d = (found && offline_q) ? ST_OFF_RM : ST_SWEEP;
			end
			ST_OFF_RM: begin
				state_d = (count_q == CNT_W'(1)) ? ST_ALL_OFF : ST_SWEEP;
			end
			ST_SWEEP: begin
				if (!p_live) begin
					state_d = ST_FIN;
				end else if (exp_p && (count_q == CNT_W'(1))) begin
					state_d = ST_ALL_OFF;
				end
			end
			ST_ALL_OFF: state_d = ST_FIN;
			ST_FIN:     state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: cell controls and the result to emit.
	always_comb begin
		touch_en = 1'b0;
		add_en   = 1'b0;
		rm_en    = 1'b0;
		rm_idx   = '0;
		p_inc    = 1'b0;
		emit_v   = 1'b0;
		flush    = 1'b0;
		emit_r   = '{ev: EV_UPDATED, slot: '0, sender: key_q, status: '0};
		case (state_q)
			ST_MSG: begin
				if (found) begin
					// Refresh the time; an offline status reports nothing.
					touch_en = 1'b1;
					if (status_q != OFFLINE_STATUS) begin
						emit_v        = 1'b1;
						emit_r.ev     = EV_UPDATED;
						emit_r.slot   = slot_t'(k) + slot_t'(1);
						emit_r.status = status_q;
					end
				end else if (count_q < CNT_W'(MAX_ENTRIES)) begin
					add_en      = 1'b1;
					emit_v      = 1'b1;
					emit_r.ev   = EV_ADDED;
					emit_r.slot = slot_t'(count_q) + slot_t'(1);
				end else begin
					emit_v    = 1'b1;
					emit_r.ev = EV_FULL;
				end
			end
			ST_OFF_RM: begin
				rm_en       = 1'b1;
				rm_idx      = k_q;
				emit_v      = 1'b1;
				emit_r.ev   = EV_OFFLINE;
				emit_r.slot = slot_t'(k_q) + slot_t'(1);
			end
			ST_SWEEP: begin
				if (exp_p) begin
					rm_en         = 1'b1;
					rm_idx        = p_idx;
					emit_v        = 1'b1;
					emit_r.ev     = EV_TIMEOUT;
					emit_r.slot   = slot_t'(p_q) + slot_t'(1);
					emit_r.sender = cell_snd[p_idx];
				end else if (p_live) begin
					p_inc = 1'b1;
				end
			end
			ST_ALL_OFF: begin
				emit_v        = 1'b1;
				emit_r.ev     = EV_ALL_OFFLINE;
				emit_r.sender = rm_snd_q;
			end
			ST_FIN: begin
				flush = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			p_q          <= '0;
			terminated_q <= 1'b0;
			timeout_q    <= TIMEOUT_RST;
		end else begin
			state_q <= state_d;
			if (timeout_we) begin
				timeout_q <= timeout_wdata;
			end
			if (accept_go) begin
				p_q <= '0;
			end else if (p_inc) begin
				p_q <= p_q + 1'b1;
			end
			if (add_en) begin
				count_q <= count_q + 1'b1;
			end else if (rm_en) begin
				count_q <= count_q - 1'b1;
				// The last live entry leaving ends all further processing.
				if (count_q == CNT_W'(1)) begin
					terminated_q <= 1'b1;
				end
			end
		end
	end

	// Transaction payload and the remembered removal details.
	always_ff @(posedge clk) begin
		if (accept_go) begin
			key_q     <= sender_id;
			status_q  <= hb_status;
			offline_q <= offline_flag;
			now_q     <= now_seconds;
		end
		if (state_q == ST_MSG) begin
			k_q <= k;
		end
		if (rm_en) begin
			rm_snd_q <= emit_r.sender;
		end
	end

	hlt_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit_v   (emit_v),
		.emit_r   (emit_r),
		.flush    (flush),
		.strobe   (result_strobe),
		.res      (res),
		.res_last (last)
	);

	assign event_res    = res.ev;
	assign slot         = res.slot;
	assign event_sender = res.sender;
	assign event_status = res.status;

endmodule

[design/hlt_checker.sv]
// Port-level checks for the heartbeat liveness table, bound to the top level.
// Depends on hlt_pkg and heartbeat_liveness_table_top.
module hlt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             result_strobe,
	input logic [2:0]       event_res,
	input hlt_pkg::slot_t   slot,
	input hlt_pkg::status_t event_status,
	input logic             last
);
	import hlt_pkg::*;

	logic seen_all_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_all_off_q <= 1'b0;
		end else if (result_strobe && (event_res == EV_ALL_OFFLINE)) begin
			seen_all_off_q <= 1'b1;
		end
	end

	// Only an update event carries a status, and no code beyond all-offline exists.
	a_event_sane: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (event_res <= EV_ALL_OFFLINE) &&
			((event_res == EV_UPDATED) || (event_status == '0)))
		else $error("result with bad event code or stray status");

	// The all-offline event closes its transaction and names no slot.
	a_all_off_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && (event_res == EV_ALL_OFFLINE)) |-> (last && (slot == '0) && !busy))
		else $error("all-offline result not final");

	// Once all senders are gone, nothing is processed until reset.
	a_terminated_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		seen_all_off_q |-> (!busy && !result_strobe))
		else $error("activity after all-offline");

	// A final result is never followed straight away by another result.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !result_strobe)
		else $error("result right after final result");

	// Work only starts from an accepted transaction.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

endmodule

bind heartbeat_liveness_table_top hlt_checker u_hlt_checker (.*);
